// ===== sv/ptrs_pkg.sv =====
// ptrs_pkg: shared types and codes for the periodic task release and select unit.
// Holds the task attribute record, evaluator flags and operation codes.
// No dependencies.
package ptrs_pkg;

    localparam int TIME_W     = 32;
    localparam int OUT_SLOT_W = 5;

    localparam logic [TIME_W-1:0] MAX_TIME = {TIME_W{1'b1}};

    // Operation codes carried by op
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_SELECT = 2'd2;
    localparam logic [1:0] OP_DONE   = 2'd3;

    // Per-slot attributes kept in the task memory next to the pending count
    typedef struct packed {
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] release_time;
        logic              is_deadline;
        logic [TIME_W-1:0] rank;
    } task_attr_t;

    // Status from the slot evaluator to the sequencer
    typedef struct packed {
        logic due;       // release time reached
        logic has_jobs;  // pending count nonzero
        logic wins;      // beats the running best
    } eval_flags_t;

endpackage

// ===== sv/ptrs_task_mem.sv =====
// ptrs_task_mem: task table storage, one write port and one registered read port.
// Generic width and depth; set by the top level of the periodic task unit.
// No package dependency.
module ptrs_task_mem #(
    parameter int DEPTH  = 32,
    parameter int DATA_W = 113,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ptrs_slot_eval.sv =====
// ptrs_slot_eval: per-slot arithmetic for release and selection.
// Wrap-aware release check and advance, saturating pending update, best compare.
// Depends on ptrs_pkg.
module ptrs_slot_eval #(
    parameter int PENDING_BITS = 16
) (
    input  ptrs_pkg::task_attr_t              attr,
    input  logic [PENDING_BITS-1:0]           pending,
    input  logic [ptrs_pkg::TIME_W-1:0]       now_time,
    input  logic [ptrs_pkg::TIME_W-1:0]       top_value,
    input  logic                              edf_mode,
    output logic [ptrs_pkg::TIME_W-1:0]       next_release,
    output logic [PENDING_BITS-1:0]           pend_inc,
    output logic [PENDING_BITS-1:0]           pend_dec,
    output ptrs_pkg::eval_flags_t             flags
);

    logic [ptrs_pkg::TIME_W-1:0] age;
    logic [ptrs_pkg::TIME_W-1:0] rank_diff;
    logic                        earlier_rank;

    assign age          = now_time - attr.release_time;
    assign rank_diff    = attr.rank - top_value;
    assign earlier_rank = rank_diff[ptrs_pkg::TIME_W-1];

    assign next_release = attr.release_time + attr.period;

    // Saturate at all ones going up and at zero going down
    assign pend_inc = (&pending) ? pending : pending + PENDING_BITS'(1);
    assign pend_dec = (|pending) ? pending - PENDING_BITS'(1) : pending;

    assign flags.due      = ~age[ptrs_pkg::TIME_W-1];
    assign flags.has_jobs = |pending;

    // Once a deadline slot is seen, only earlier deadline slots replace it
    always_comb
    begin
        if (edf_mode)
        begin
            flags.wins = attr.is_deadline & earlier_rank;
        end
        else
        begin
            flags.wins = attr.is_deadline | (attr.rank < top_value);
        end
    end

endmodule

// ===== sv/periodic_task_release_and_select_unit.sv =====
// periodic_task_release_and_select_unit: top level of the task release and select block.
// Sequences table writes, release ticks, best-slot selects and job completions.
// Depends on ptrs_pkg, ptrs_task_mem and ptrs_slot_eval.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  request  | req_valid, req_stall | op, slot, now_time, slot_valid, slot_period,
//           |                      | slot_first_release, slot_is_deadline,
//           |                      | slot_priority
//  response | rsp_valid, rsp_stall | best_slot, switch_needed, released_any
//
// Tick and select scan slots 1 to NUM_SLOTS - 1 and accept nothing until done:
// the task memory has one read port and the scan reads one slot per cycle.
// Write goes straight to its response; job done does one read, then a write back.
// Reset clears the live bits, the current slot and the handshake state at once;
// there is no clearing pass, and the other table fields are undefined until written.
// A stalled response holds in the output register; the next transaction is still
// accepted and runs, and waits for the output register only at its end.
module periodic_task_release_and_select_unit #(
    parameter int NUM_SLOTS    = 32,
    parameter int PENDING_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  op,
    input  logic [4:0]  slot,
    input  logic [31:0] now_time,
    input  logic        slot_valid,
    input  logic [31:0] slot_period,
    input  logic [31:0] slot_first_release,
    input  logic        slot_is_deadline,
    input  logic [31:0] slot_priority,

    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [4:0]  best_slot,
    output logic        switch_needed,
    output logic        released_any
);

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int ATTR_W  = $bits(ptrs_pkg::task_attr_t);
    localparam int ENTRY_W = ATTR_W + PENDING_BITS;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_JOB  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [31:0]          now_reg, now_next;
    logic [SLOT_W-1:0]    issue_idx_reg, issue_idx_next;
    logic                 issue_more_reg, issue_more_next;
    logic                 proc_valid_reg, proc_valid_next;
    logic [SLOT_W-1:0]    proc_idx_reg, proc_idx_next;
    logic [NUM_SLOTS-1:0] live_reg, live_next;
    logic [SLOT_W-1:0]    current_reg, current_next;
    logic [SLOT_W-1:0]    best_reg, best_next;
    logic [31:0]          top_reg, top_next;
    logic                 edf_reg, edf_next;
    logic                 rel_reg, rel_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [4:0]           best_slot_reg;
    logic                 switch_reg;
    logic                 released_reg;

    logic                 req_acc;
    logic                 slot_ok;
    logic [SLOT_W-1:0]    slot_idx;
    logic                 out_free;
    logic                 out_load;
    logic                 switch_calc;

    // Task memory ports
    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic                 rd_en;
    logic [SLOT_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]   rd_data;

    ptrs_pkg::task_attr_t  wr_attr;
    ptrs_pkg::task_attr_t  rd_attr;
    ptrs_pkg::task_attr_t  upd_attr;
    logic [PENDING_BITS-1:0] rd_pend;
    logic [31:0]             eval_release;
    logic [PENDING_BITS-1:0] eval_inc;
    logic [PENDING_BITS-1:0] eval_dec;
    ptrs_pkg::eval_flags_t   eval_flags;
    logic                    proc_live;

    ptrs_task_mem #(
        .DEPTH  (NUM_SLOTS),
        .DATA_W (ENTRY_W),
        .ADDR_W (SLOT_W)
    ) u_task_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_attr = ptrs_pkg::task_attr_t'(rd_data[ENTRY_W-1:PENDING_BITS]);
    assign rd_pend = rd_data[PENDING_BITS-1:0];

    // The scan compares against the tick time captured at acceptance
    ptrs_slot_eval #(
        .PENDING_BITS (PENDING_BITS)
    ) u_slot_eval (
        .attr         (rd_attr),
        .pending      (rd_pend),
        .now_time     (now_reg),
        .top_value    (top_reg),
        .edf_mode     (edf_reg),
        .next_release (eval_release),
        .pend_inc     (eval_inc),
        .pend_dec     (eval_dec),
        .flags        (eval_flags)
    );

    // Request side: one transaction at a time, taken only from idle
    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc   = req_valid & ~req_stall;
    assign slot_ok   = (32'(slot) < 32'(NUM_SLOTS));
    assign slot_idx  = SLOT_W'(slot);
    assign proc_live = live_reg[proc_idx_reg];

    assign wr_attr.period       = slot_period;
    assign wr_attr.release_time = slot_first_release;
    assign wr_attr.is_deadline  = slot_is_deadline;
    assign wr_attr.rank         = slot_priority;

    // Release keeps the slot's attributes and moves only its release time
    always_comb
    begin
        upd_attr              = rd_attr;
        upd_attr.release_time = eval_release;
    end

    // Response side: the output register frees when its transaction leaves
    assign out_free    = ~rsp_valid_reg | ~rsp_stall;
    assign out_load    = (state_reg == ST_DONE) & out_free;
    assign switch_calc = (op_reg == ptrs_pkg::OP_SELECT) & (best_reg != current_reg);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        issue_idx_next  = issue_idx_reg;
        issue_more_next = issue_more_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        live_next       = live_reg;
        current_next    = current_reg;
        best_next       = best_reg;
        top_next        = top_reg;
        edf_next        = edf_reg;
        rel_next        = rel_reg;
        rsp_valid_next  = rsp_valid_reg & rsp_stall;
        wr_en           = 1'b0;
        wr_addr         = proc_idx_reg;
        wr_data         = {upd_attr, eval_inc};
        rd_en           = 1'b0;
        rd_addr         = issue_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    op_next   = op;
                    now_next  = now_time;
                    best_next = '0;
                    top_next  = ptrs_pkg::MAX_TIME;
                    edf_next  = 1'b0;
                    rel_next  = 1'b0;
                    unique case (op)
                        ptrs_pkg::OP_WRITE:
                        begin
                            // Load the slot and clear its pending count
                            if (slot_ok)
                            begin
                                wr_en               = 1'b1;
                                wr_addr             = slot_idx;
                                wr_data             = {wr_attr, PENDING_BITS'(0)};
                                live_next[slot_idx] = slot_valid;
                            end
                            state_next = ST_DONE;
                        end
                        ptrs_pkg::OP_DONE:
                        begin
                            if (slot_ok)
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = slot_idx;
                                proc_idx_next = slot_idx;
                                state_next    = ST_JOB;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        ptrs_pkg::OP_TICK,
                        ptrs_pkg::OP_SELECT:
                        begin
                            // Slot 0 is the idle task and is never scanned
                            issue_idx_next  = FIRST_SLOT;
                            issue_more_next = 1'b1;
                            state_next      = ST_SCAN;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue stage: read one slot per cycle
                if (issue_more_reg)
                begin
                    rd_en           = 1'b1;
                    rd_addr         = issue_idx_reg;
                    proc_valid_next = 1'b1;
                    proc_idx_next   = issue_idx_reg;
                    issue_more_next = (issue_idx_reg != LAST_SLOT);
                    issue_idx_next  = issue_idx_reg + FIRST_SLOT;
                end
                // Process stage: evaluate the slot read last cycle; a tick writes it
                // back while the next slot is being read, so addresses never collide
                if (proc_valid_reg & proc_live)
                begin
                    if (op_reg == ptrs_pkg::OP_TICK)
                    begin
                        if (eval_flags.due)
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = proc_idx_reg;
                            wr_data  = {upd_attr, eval_inc};
                            rel_next = 1'b1;
                        end
                    end
                    else if (eval_flags.has_jobs & eval_flags.wins)
                    begin
                        best_next = proc_idx_reg;
                        top_next  = rd_attr.rank;
                        edf_next  = edf_reg | rd_attr.is_deadline;
                    end
                end
                if (proc_valid_reg & (proc_idx_reg == LAST_SLOT))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_JOB:
            begin
                // Write back the decremented count; drop the write when already zero
                if (eval_flags.has_jobs)
                begin
                    wr_en   = 1'b1;
                    wr_addr = proc_idx_reg;
                    wr_data = {rd_attr, eval_dec};
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (op_reg == ptrs_pkg::OP_SELECT)
                    begin
                        current_next = best_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_more_reg <= 1'b0;
            proc_valid_reg <= 1'b0;
            live_reg       <= '0;
            current_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_more_reg <= issue_more_next;
            proc_valid_reg <= proc_valid_next;
            live_reg       <= live_next;
            current_reg    <= current_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        now_reg       <= now_next;
        issue_idx_reg <= issue_idx_next;
        proc_idx_reg  <= proc_idx_next;
        best_reg      <= best_next;
        top_reg       <= top_next;
        edf_reg       <= edf_next;
        rel_reg       <= rel_next;
        if (out_load)
        begin
            best_slot_reg <= ptrs_pkg::OUT_SLOT_W'(best_reg);
            switch_reg    <= switch_calc;
            released_reg  <= rel_reg;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign best_slot     = best_slot_reg;
    assign switch_needed = switch_reg;
    assign released_any  = released_reg;

    // A write-back never targets the slot being read in the same cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("task memory read and write hit the same slot");

    // The process stage only runs during a scan
    a_proc_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        proc_valid_reg |-> (state_reg == ST_SCAN))
        else $error("slot evaluated outside a scan");

    // A tick result never carries a selection, a select never reports a release
    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(released_any && (switch_needed || (best_slot != 5'd0))))
        else $error("response mixes tick and select results");

    // A select updates the current slot to the slot it reports
    a_current_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (op_reg == ptrs_pkg::OP_SELECT)) |=> (current_reg == $past(best_reg)))
        else $error("current slot not recorded on select");

endmodule

// ===== bench/ptrs_schedule_checker.sv =====
// ptrs_schedule_checker: watches the request and response channels of the task release
// and select unit, predicts every response from its own task table and compares fields.
// Depends on ptrs_pkg.
module ptrs_schedule_checker #(
    parameter int NUM_SLOTS    = 32,
    parameter int PENDING_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    input  logic        req_stall,
    input  logic [1:0]  op,
    input  logic [4:0]  slot,
    input  logic [31:0] now_time,
    input  logic        slot_valid,
    input  logic [31:0] slot_period,
    input  logic [31:0] slot_first_release,
    input  logic        slot_is_deadline,
    input  logic [31:0] slot_priority,

    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [4:0]  best_slot,
    input  logic        switch_needed,
    input  logic        released_any,

    output int          fail_count,
    output int          awaited
);

    typedef struct packed {
        logic [4:0] best;
        logic       switch_flag;
        logic       released;
    } sched_rsp_t;

    localparam bit [PENDING_BITS-1:0] JOBS_MAX = '1;

    // Own copy of the task table
    bit                    live_tbl     [NUM_SLOTS];
    bit [31:0]             period_tbl   [NUM_SLOTS];
    bit [31:0]             release_tbl  [NUM_SLOTS];
    bit                    deadline_tbl [NUM_SLOTS];
    bit [31:0]             rank_tbl     [NUM_SLOTS];
    bit [PENDING_BITS-1:0] jobs_tbl     [NUM_SLOTS];
    int                    running_slot;

    sched_rsp_t expected_responses[$];

    // Wrap-aware: a comes before b modulo 2^32
    function automatic bit wraps_earlier(bit [31:0] a, bit [31:0] b);
        bit [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ptrs check: %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic predict_schedule(output sched_rsp_t r);
        int        i;
        int        best_idx;
        bit [31:0] top_rank;
        bit        found_deadline;
        r = '0;
        best_idx = 0;
        case (op)
            ptrs_pkg::OP_WRITE:
                if (slot < NUM_SLOTS)
                begin
                    live_tbl[slot]     = slot_valid;
                    period_tbl[slot]   = slot_period;
                    release_tbl[slot]  = slot_first_release;
                    deadline_tbl[slot] = slot_is_deadline;
                    rank_tbl[slot]     = slot_priority;
                    jobs_tbl[slot]     = '0;
                end
            ptrs_pkg::OP_TICK:
                for (i = 1; i < NUM_SLOTS; i++)
                begin
                    if (live_tbl[i] && !wraps_earlier(now_time, release_tbl[i]))
                    begin
                        release_tbl[i] += period_tbl[i];
                        if (jobs_tbl[i] != JOBS_MAX)
                            jobs_tbl[i]++;
                        r.released = 1'b1;
                    end
                end
            ptrs_pkg::OP_SELECT:
            begin
                top_rank = ptrs_pkg::MAX_TIME;
                found_deadline = 1'b0;
                for (i = 1; i < NUM_SLOTS; i++)
                begin
                    if (!live_tbl[i] || jobs_tbl[i] == '0)
                        continue;
                    if (found_deadline)
                    begin
                        if (deadline_tbl[i] && wraps_earlier(rank_tbl[i], top_rank))
                        begin
                            top_rank = rank_tbl[i];
                            best_idx = i;
                        end
                    end
                    else if (deadline_tbl[i])
                    begin
                        found_deadline = 1'b1;
                        top_rank = rank_tbl[i];
                        best_idx = i;
                    end
                    else if (rank_tbl[i] < top_rank)
                    begin
                        top_rank = rank_tbl[i];
                        best_idx = i;
                    end
                end
                r.best = best_idx[4:0];
                r.switch_flag = (best_idx != running_slot);
                running_slot = best_idx;
            end
            default:
                if (slot < NUM_SLOTS && jobs_tbl[slot] != '0)
                    jobs_tbl[slot]--;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        sched_rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                live_tbl[i]     = 1'b0;
                period_tbl[i]   = '0;
                release_tbl[i]  = '0;
                deadline_tbl[i] = 1'b0;
                rank_tbl[i]     = '0;
                jobs_tbl[i]     = '0;
            end
            running_slot = 0;
            expected_responses.delete();
            fail_count = 0;
            awaited <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_responses.size() == 0)
                    report_mismatch("response with no request outstanding", best_slot, -1);
                else
                begin
                    want = expected_responses.pop_front();
                    if (best_slot !== want.best)
                        report_mismatch("best_slot", best_slot, want.best);
                    if (switch_needed !== want.switch_flag)
                        report_mismatch("switch_needed", switch_needed, want.switch_flag);
                    if (released_any !== want.released)
                        report_mismatch("released_any", released_any, want.released);
                end
            end
            if (req_valid && !req_stall)
            begin
                predict_schedule(want);
                expected_responses.push_back(want);
            end
            awaited <= expected_responses.size();
        end
    end

endmodule

// ===== bench/periodic_task_release_and_select_unit_test.sv =====
// periodic_task_release_and_select_unit_test: drives the task release and select unit
// with directed and random transactions under random idling and gives the verdict.
// Depends on ptrs_pkg, periodic_task_release_and_select_unit and ptrs_schedule_checker.
module periodic_task_release_and_select_unit_test;

    localparam int HALF_PERIOD    = 4;
    localparam int ITEM_TARGET    = 1450;
    localparam int LONG_HOLD      = 300;    // receiver hold-off, long enough to back up
    localparam int SETTLE_CYCLES  = 80;     // longer than a full scan
    localparam int WATCHDOG_LIMIT = 2000;   // well above LONG_HOLD plus one scan

    logic        clk                = 1'b0;
    logic        rst_n              = 1'b0;
    logic        req_valid          = 1'b0;
    logic [1:0]  op                 = ptrs_pkg::OP_SELECT;
    logic [4:0]  slot               = '0;
    logic [31:0] now_time           = '0;
    logic        slot_valid         = 1'b0;
    logic [31:0] slot_period        = '0;
    logic [31:0] slot_first_release = '0;
    logic        slot_is_deadline   = 1'b0;
    logic [31:0] slot_priority      = '0;
    logic        rsp_stall          = 1'b0;

    logic        req_stall;
    logic        rsp_valid;
    logic [4:0]  best_slot;
    logic        switch_needed;
    logic        released_any;

    int fail_count;
    int awaited;
    int sent_count   = 0;
    int idle_cycles  = 0;
    bit calm         = 1'b0;   // set for the last stretch: no idling on either side
    bit hold_request = 1'b0;   // asks the receiver for one long hold-off

    periodic_task_release_and_select_unit uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req_valid),
        .req_stall          (req_stall),
        .op                 (op),
        .slot               (slot),
        .now_time           (now_time),
        .slot_valid         (slot_valid),
        .slot_period        (slot_period),
        .slot_first_release (slot_first_release),
        .slot_is_deadline   (slot_is_deadline),
        .slot_priority      (slot_priority),
        .rsp_valid          (rsp_valid),
        .rsp_stall          (rsp_stall),
        .best_slot          (best_slot),
        .switch_needed      (switch_needed),
        .released_any       (released_any)
    );

    ptrs_schedule_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req_valid),
        .req_stall          (req_stall),
        .op                 (op),
        .slot               (slot),
        .now_time           (now_time),
        .slot_valid         (slot_valid),
        .slot_period        (slot_period),
        .slot_first_release (slot_first_release),
        .slot_is_deadline   (slot_is_deadline),
        .slot_priority      (slot_priority),
        .rsp_valid          (rsp_valid),
        .rsp_stall          (rsp_stall),
        .best_slot          (best_slot),
        .switch_needed      (switch_needed),
        .released_any       (released_any),
        .fail_count         (fail_count),
        .awaited            (awaited)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Offer one transaction and hold it until accepted, then maybe idle for a burst.
    // Valid stays high into the next call when no burst is drawn, so it is never
    // lowered and raised in one step.
    task automatic send_request(input logic [1:0] o, input logic [4:0] s,
                                input logic [31:0] t, input logic v,
                                input logic [31:0] per, input logic [31:0] rel,
                                input logic dl, input logic [31:0] rank);
        req_valid          <= 1'b1;
        op                 <= o;
        slot               <= s;
        now_time           <= t;
        slot_valid         <= v;
        slot_period        <= per;
        slot_first_release <= rel;
        slot_is_deadline   <= dl;
        slot_priority      <= rank;
        do
            @(posedge clk);
        while (req_stall);
        sent_count++;
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic write_task_slot(input logic [4:0] s, input logic v, input logic [31:0] per,
                                   input logic [31:0] rel, input logic dl,
                                   input logic [31:0] rank);
        send_request(ptrs_pkg::OP_WRITE, s, $urandom, v, per, rel, dl, rank);
    endtask

    // Non-write transaction: fill the unused slot fields with junk
    task automatic send_op(input logic [1:0] o, input logic [4:0] s, input logic [31:0] t);
        send_request(o, s, t, 1'($urandom), $urandom, $urandom, 1'($urandom), $urandom);
    endtask

    // Hold until every expected response has been seen; the count is registered
    task automatic wait_drained();
        do
            @(posedge clk);
        while (awaited != 0);
    endtask

    // Response side: random stall bursts, one long hold-off on request, none when calm
    initial
    begin : response_pacing
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                rsp_stall <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        bit [31:0] sim_clock;
        bit [31:0] per;
        bit [31:0] rel;
        bit [31:0] rank;
        bit [4:0]  target;
        bit        is_dl;
        int        pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Select and job done on an empty table: idle, no switch,
        // and the pending count stays at zero.
        send_op(ptrs_pkg::OP_SELECT, 5'd0, 32'd0);
        send_op(ptrs_pkg::OP_DONE, 5'd5, 32'd0);
        // Slot 0 is stored but never scanned; slot 31 with the all-ones fixed rank never wins
        write_task_slot(5'd0, 1'b1, 32'd1, 32'd0, 1'b1, 32'd0);
        write_task_slot(5'd31, 1'b1, 32'd10, 32'd0, 1'b0, ptrs_pkg::MAX_TIME);
        write_task_slot(5'd1, 1'b1, 32'd5, 32'd10, 1'b0, 32'd50);
        // Deadline slots whose release and rank straddle the wrap point
        write_task_slot(5'd2, 1'b1, 32'd7, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFF0);
        write_task_slot(5'd3, 1'b1, 32'h8000_0000, 32'd0, 1'b1, 32'd5);
        // Dead slot with all-ones period: never released
        write_task_slot(5'd4, 1'b0, ptrs_pkg::MAX_TIME, 32'd0, 1'b1, 32'd0);
        send_op(ptrs_pkg::OP_TICK, 5'd31, 32'd0);
        send_op(ptrs_pkg::OP_SELECT, 5'd0, ptrs_pkg::MAX_TIME); // wrap-aware deadline wins
        send_op(ptrs_pkg::OP_SELECT, 5'd0, 32'd0);      // same slot again, no switch
        send_op(ptrs_pkg::OP_DONE, 5'd2, 32'd0);
        send_op(ptrs_pkg::OP_DONE, 5'd2, 32'd0);        // already empty, saturate at zero
        send_op(ptrs_pkg::OP_SELECT, 5'd0, 32'd0);
        // Far behind: still only one release per slot per tick
        send_op(ptrs_pkg::OP_TICK, 5'd0, 32'd1000);
        write_task_slot(5'd5, 1'b1, 32'd1, 32'd0, 1'b0, 32'd50);   // ties slot 1
        send_op(ptrs_pkg::OP_TICK, 5'd0, 32'd1000);
        // Rewrite clears pending jobs; all-zero contents
        write_task_slot(5'd2, 1'b0, 32'd0, 32'd0, 1'b0, 32'd0);
        send_op(ptrs_pkg::OP_DONE, 5'd3, 32'd0);
        send_op(ptrs_pkg::OP_SELECT, 5'd0, 32'd0);      // fixed-priority tie: lower slot
        send_op(ptrs_pkg::OP_DONE, 5'd1, 32'd0);
        send_op(ptrs_pkg::OP_DONE, 5'd1, 32'd0);
        send_op(ptrs_pkg::OP_SELECT, 5'd0, 32'd0);
        send_op(ptrs_pkg::OP_DONE, 5'd5, 32'd0);
        send_op(ptrs_pkg::OP_SELECT, 5'd0, 32'd0);      // only slot 31 pending: back to idle

        // Random part: mostly a coherent timeline with a small working set of slots,
        // plus some transactions with every field drawn at random.
        sim_clock = 32'd2000;
        while (sent_count < ITEM_TARGET)
        begin
            if (sent_count == 400)
                hold_request = 1'b1;
            if (sent_count == 800)
            begin
                req_valid <= 1'b0;
                wait_drained();
            end
            if (sent_count == ITEM_TARGET - 150)
                calm = 1'b1;

            if ($urandom_range(0, 9) == 0)
                send_request(2'($urandom), 5'($urandom), $urandom, 1'($urandom), $urandom,
                             $urandom, 1'($urandom), $urandom);
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    target = ($urandom_range(0, 4) == 0) ? 5'($urandom)
                                                         : 5'($urandom_range(1, 7));
                    is_dl = 1'($urandom);
                    per = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 40);
                    rel = ($urandom_range(0, 9) == 0) ? $urandom
                                                      : sim_clock + $urandom_range(0, 30);
                    if (is_dl)
                        rank = ($urandom_range(0, 9) == 0) ? $urandom
                                                           : sim_clock + $urandom_range(0, 120);
                    else
                        case ($urandom_range(0, 9))
                            0:       rank = $urandom;
                            1:       rank = ptrs_pkg::MAX_TIME;
                            default: rank = $urandom_range(0, 15);
                        endcase
                    write_task_slot(target, $urandom_range(0, 9) != 0, per, rel, is_dl, rank);
                end
                else if (pick < 50)
                begin
                    // Advance time in small steps; now and then jump anywhere
                    if ($urandom_range(0, 49) == 0)
                        sim_clock = $urandom;
                    else
                        sim_clock += $urandom_range(0, 25);
                    send_op(ptrs_pkg::OP_TICK, 5'($urandom), sim_clock);
                end
                else if (pick < 80)
                    send_op(ptrs_pkg::OP_SELECT, 5'($urandom), $urandom);
                else
                    send_op(ptrs_pkg::OP_DONE, ($urandom_range(0, 4) == 0)
                                                   ? 5'($urandom)
                                                   : 5'($urandom_range(1, 7)),
                            $urandom);
            end
        end

        // Drain, let the block settle, then give the verdict
        req_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && awaited == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
